@@ rtl/drq_pkg.sv @@
package drq_pkg;

    // Table size and coordinate width of the block.
    parameter int TABLE_DEPTH = 16;
    parameter int COORD_BITS  = 9;

    // Fixed field widths of the stream ports.
    parameter int IN_COORD_W  = 9;
    parameter int OUT_COORD_W = 9;
    parameter int SLOT_W      = 4;
    parameter int TOTAL_W     = 5;
    parameter int IN_DATA_W   = 40;
    parameter int IN_USER_W   = 2;
    parameter int OUT_DATA_W  = 48;
    parameter int OUT_USER_W  = 3;

    typedef enum logic [1:0] {
        CMD_PUSH        = 2'd0,
        CMD_CLEAR_QUEUE = 2'd1,
        CMD_CLEAR_FULL  = 2'd2,
        CMD_DRAIN       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OUT_APPENDED    = 3'd0,
        OUT_DROPPED     = 3'd1,
        OUT_REPLACED    = 3'd2,
        OUT_OVERFLOW    = 3'd3,
        OUT_IGNORED     = 3'd4,
        OUT_CLEARED     = 3'd5,
        OUT_DRAINED     = 3'd6,
        OUT_DRAIN_EMPTY = 3'd7
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DRAIN
    } state_t;

endpackage

@@ rtl/drq_table.sv @@
// Single-port-write, single-port-read table with a registered read.
module drq_table #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 36,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/dirty_rectangle_queue_top.sv @@
// Channel      Direction  Fields
// s_axis_*     in         tuser: command; tdata: top_row, left_column, height, width
// m_axis_*     out        tuser: outcome; tdata: slot, out_row, out_column,
//                         out_height, out_width, entry_total, queue_mode_on; tlast: last
//
// A push in queue mode compares the stored entries in order, one entry per cycle, and stops
// at the first containment match, else it appends or overflows; a drain hands out every stored
// entry in order. Reset empties the table and turns queue mode on; contents are not cleared,
// since only entries below the count are read. Input is taken while a result waits; the
// sequencer stalls only when it has a result to hand over and the output register is still occupied.
module dirty_rectangle_queue_top
    import drq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [8:0] top_row, [17:9] left_column, [26:18] height, [35:27] width, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [IN_USER_W-1:0]  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] slot, [12:4] out_row, [21:13] out_column, [30:22] out_height,
    // [39:31] out_width, [44:40] entry_total, [45] queue_mode_on, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] outcome
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int END_W  = COORD_BITS + 1;
    localparam int ENTRY_W = 4 * COORD_BITS;

    // Sequencer and table bookkeeping.
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   mode_reg, mode_next;

    // The rectangle of the transaction being worked on, with its exact far edges.
    logic [COORD_BITS-1:0]  nrow_reg, nrow_next;
    logic [COORD_BITS-1:0]  ncol_reg, ncol_next;
    logic [COORD_BITS-1:0]  nhgt_reg, nhgt_next;
    logic [COORD_BITS-1:0]  nwid_reg, nwid_next;
    logic [END_W-1:0]       nrow_end_reg, nrow_end_next;
    logic [END_W-1:0]       ncol_end_reg, ncol_end_next;

    // Output register.
    logic                   out_valid_reg;
    outcome_t               out_outcome_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [OUT_COORD_W-1:0] out_row_reg, out_col_reg, out_hgt_reg, out_wid_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic                   out_mode_reg;
    logic                   out_last_reg;

    // Table port.
    logic                   rd_en, wr_en;
    logic [IDX_W-1:0]       rd_addr, wr_addr;
    logic [ENTRY_W-1:0]     rd_data, wr_data;

    // Result produced this cycle.
    logic                   emit;
    outcome_t               e_outcome;
    logic [IDX_W-1:0]       e_slot;
    logic                   e_show;
    logic [CNT_W-1:0]       e_total;
    logic                   e_mode;
    logic                   e_last;

    logic                   accept;
    cmd_t                   in_cmd;
    logic                   out_free;
    logic [COORD_BITS-1:0]  erow, ecol, ehgt, ewid;
    logic [END_W-1:0]       erow_end, ecol_end;
    logic                   new_in_entry, entry_in_new, last_entry;

    drq_table #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = cmd_t'(s_axis_tuser[1:0]);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Entry read in the previous cycle, and both containment tests against it.
    assign erow     = rd_data[COORD_BITS-1:0];
    assign ecol     = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign ehgt     = rd_data[3*COORD_BITS-1:2*COORD_BITS];
    assign ewid     = rd_data[4*COORD_BITS-1:3*COORD_BITS];
    assign erow_end = {1'b0, erow} + {1'b0, ehgt};
    assign ecol_end = {1'b0, ecol} + {1'b0, ewid};

    assign new_in_entry = (nrow_reg >= erow) && (nrow_end_reg <= erow_end) &&
                          (ncol_reg >= ecol) && (ncol_end_reg <= ecol_end);
    assign entry_in_new = (erow >= nrow_reg) && (erow_end <= nrow_end_reg) &&
                          (ecol >= ncol_reg) && (ecol_end <= ncol_end_reg);
    assign last_entry   = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));

    // Results, table accesses.
    always_comb
    begin
        emit      = 1'b0;
        e_outcome = OUT_APPENDED;
        e_slot    = '0;
        e_show    = 1'b0;
        e_total   = count_reg;
        e_mode    = mode_reg;
        e_last    = 1'b1;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = idx_reg;
        wr_data   = {nwid_reg, nhgt_reg, ncol_reg, nrow_reg};

        case (state_reg)
            ST_IDLE:
            begin
                // Start the first read as the transaction is taken.
                if (accept && (count_reg != '0) &&
                    (((in_cmd == CMD_PUSH) && mode_reg) || (in_cmd == CMD_DRAIN)))
                begin
                    rd_en = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (new_in_entry)
                begin
                    emit      = out_free;
                    e_outcome = OUT_DROPPED;
                    e_slot    = idx_reg;
                end
                else if (entry_in_new)
                begin
                    emit      = out_free;
                    e_outcome = OUT_REPLACED;
                    e_slot    = idx_reg;
                    wr_en     = out_free;
                end
                else if (!last_entry)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                emit = out_free;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (!mode_reg)
                        begin
                            e_outcome = OUT_IGNORED;
                        end
                        else if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            e_outcome = OUT_OVERFLOW;
                            e_mode    = 1'b0;
                        end
                        else
                        begin
                            e_outcome = OUT_APPENDED;
                            e_slot    = IDX_W'(count_reg);
                            e_total   = count_reg + CNT_W'(1);
                            wr_en     = out_free;
                            wr_addr   = IDX_W'(count_reg);
                        end
                    end
                    CMD_CLEAR_QUEUE:
                    begin
                        e_outcome = OUT_CLEARED;
                        e_total   = '0;
                        e_mode    = 1'b1;
                    end
                    CMD_CLEAR_FULL:
                    begin
                        e_outcome = OUT_CLEARED;
                        e_total   = '0;
                        e_mode    = 1'b0;
                    end
                    default:
                    begin
                        e_outcome = OUT_DRAIN_EMPTY;
                        e_total   = '0;
                    end
                endcase
            end
            ST_DRAIN:
            begin
                emit      = out_free;
                e_outcome = OUT_DRAINED;
                e_slot    = idx_reg;
                e_show    = 1'b1;
                e_total   = '0;
                e_last    = last_entry;
                if (out_free && !last_entry)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer and bookkeeping.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        mode_next     = mode_reg;
        nrow_next     = nrow_reg;
        ncol_next     = ncol_reg;
        nhgt_next     = nhgt_reg;
        nwid_next     = nwid_reg;
        nrow_end_next = nrow_end_reg;
        ncol_end_next = ncol_end_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = in_cmd;
                    idx_next      = '0;
                    nrow_next     = COORD_BITS'(s_axis_tdata[8:0]);
                    ncol_next     = COORD_BITS'(s_axis_tdata[17:9]);
                    nhgt_next     = COORD_BITS'(s_axis_tdata[26:18]);
                    nwid_next     = COORD_BITS'(s_axis_tdata[35:27]);
                    nrow_end_next = {1'b0, nrow_next} + {1'b0, nhgt_next};
                    ncol_end_next = {1'b0, ncol_next} + {1'b0, nwid_next};
                    if ((in_cmd == CMD_PUSH) && mode_reg && (count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else if ((in_cmd == CMD_DRAIN) && (count_reg != '0))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (new_in_entry || entry_in_new)
                begin
                    if (emit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (last_entry)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (emit)
                begin
                    count_next = e_total;
                    mode_next  = e_mode;
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (emit)
                begin
                    if (last_entry)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mode_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mode_reg  <= mode_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        nrow_reg     <= nrow_next;
        ncol_reg     <= ncol_next;
        nhgt_reg     <= nhgt_next;
        nwid_reg     <= nwid_next;
        nrow_end_reg <= nrow_end_next;
        ncol_end_reg <= ncol_end_next;
        if (emit)
        begin
            out_outcome_reg <= e_outcome;
            out_slot_reg    <= SLOT_W'(e_slot);
            out_row_reg     <= e_show ? OUT_COORD_W'(erow) : '0;
            out_col_reg     <= e_show ? OUT_COORD_W'(ecol) : '0;
            out_hgt_reg     <= e_show ? OUT_COORD_W'(ehgt) : '0;
            out_wid_reg     <= e_show ? OUT_COORD_W'(ewid) : '0;
            out_total_reg   <= TOTAL_W'(e_total);
            out_mode_reg    <= e_mode;
            out_last_reg    <= e_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_outcome_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_mode_reg, out_total_reg, out_wid_reg, out_hgt_reg,
                            out_col_reg, out_row_reg, out_slot_reg};

    // The count never runs past the table.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // Scans and drains only look at stored entries.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)) |->
        (CNT_W'(idx_reg) < count_reg))
        else $error("table index beyond stored entries");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwrote a pending result");

    // An overflow leaves the block in full-refresh mode.
    a_overflow_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (e_outcome == OUT_OVERFLOW)) |=> !mode_reg)
        else $error("overflow did not leave queue mode");

    // The final drained entry empties the table.
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (e_outcome == OUT_DRAINED) && e_last) |=> (count_reg == '0))
        else $error("drain did not empty the table");

endmodule
